@@ rtl/core/sdzt_pkg.sv @@
// shared types, codes and the zone classifier of the session distance zone tracker
// no dependencies; imported by the controller, the datapath, the top level and the checker
package sdzt_pkg;

	localparam int IN_DATA_W  = 64;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;
	localparam int LIMIT_W    = 16;
	localparam int KEY_W      = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [15:0] DIST_NONE = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_CREATE  = 3'd0,
		MODE_DESTROY = 3'd1,
		MODE_START   = 3'd2,
		MODE_STOP    = 3'd3,
		MODE_RESULT  = 3'd4,
		MODE_QUERY   = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ZN_LOCKED   = 3'd0,
		ZN_APPROACH = 3'd1,
		ZN_UNLOCK   = 3'd2,
		ZN_ENTRY    = 3'd3,
		ZN_INSIDE   = 3'd4
	} zone_t;

	typedef enum logic [1:0] {
		REG_INSIDE   = 2'd0,
		REG_ENTRY    = 2'd1,
		REG_UNLOCK   = 2'd2,
		REG_APPROACH = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CMP  = 2'd1,
		ST_SEL  = 2'd2,
		ST_EXEC = 2'd3
	} state_t;

	// controller to datapath strobes
	typedef struct packed {
		logic capture;
		logic compare;
		logic select;
		logic execute;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_full;
	} stat_t;

	function automatic zone_t zone_of(input logic [15:0] d, input logic [15:0] in_lim,
			input logic [15:0] ent_lim, input logic [15:0] unl_lim, input logic [15:0] app_lim);
		zone_t z;
		if (d <= in_lim)
			z = ZN_INSIDE;
		else if (d <= ent_lim)
			z = ZN_ENTRY;
		else if (d <= unl_lim)
			z = ZN_UNLOCK;
		else if (d <= app_lim)
			z = ZN_APPROACH;
		else
			z = ZN_LOCKED;
		return z;
	endfunction

endpackage

@@ rtl/core/sdzt_ctrl.sv @@
// sequencing state machine of the session distance zone tracker
// depends on sdzt_pkg; drives the datapath strobes
module sdzt_ctrl
	import sdzt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  logic  m_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.compare = 1'b1;
				state_d = ST_SEL;
			end
			ST_SEL: begin
				cmd.select = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				// result register must be free or drained this cycle
				if (!stat.out_full || m_tready) begin
					cmd.execute = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

@@ rtl/core/sdzt_datapath.sv @@
// session table, lookup, zone classifier and result register
// depends on sdzt_pkg; steered by sdzt_ctrl
module sdzt_datapath
	import sdzt_pkg::*;
#(
	parameter int SESSION_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output stat_t                 stat,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LIMIT_W-1:0]    cfg_wdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	localparam int SLOT_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;

	// limits
	logic [LIMIT_W-1:0] inside_q, entry_q, unlock_q, approach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q   <= '0;
			entry_q    <= '0;
			unlock_q   <= '0;
			approach_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INSIDE:   inside_q   <= cfg_wdata;
				REG_ENTRY:    entry_q    <= cfg_wdata;
				REG_UNLOCK:   unlock_q   <= cfg_wdata;
				REG_APPROACH: approach_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// captured beat
	logic [2:0]       mode_q;
	logic [7:0]       chan_q, pre_q;
	logic [KEY_W-1:0] key_q;
	logic [15:0]      meas_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= s_tuser;
			chan_q <= s_tdata[7:0];
			pre_q  <= s_tdata[15:8];
			key_q  <= s_tdata[47:16];
			meas_q <= s_tdata[63:48];
		end
	end

	// table
	logic [SESSION_SLOTS-1:0] active_q, ranging_q;
	logic [KEY_W-1:0]         ident_q [SESSION_SLOTS];
	logic [15:0]              dist_mem [SESSION_SLOTS];
	zone_t                    zone_mem [SESSION_SLOTS];

	// compare stage
	logic [SESSION_SLOTS-1:0] match_s1, free_s1;
	zone_t                    zone_s1;

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			for (int i = 0; i < SESSION_SLOTS; i++)
				match_s1[i] <= active_q[i] && (ident_q[i] == key_q);
			free_s1 <= ~active_q;
			zone_s1 <= zone_of(meas_q, inside_q, entry_q, unlock_q, approach_q);
		end
	end

	// select stage: isolate lowest set bit, then encode
	logic [SESSION_SLOTS-1:0] hit_oh, free_oh;
	logic [SLOT_W-1:0]        hit_idx_c, free_idx_c;

	assign hit_oh  = match_s1 & (~match_s1 + SESSION_SLOTS'(1));
	assign free_oh = free_s1 & (~free_s1 + SESSION_SLOTS'(1));

	always_comb begin
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = 0; i < SESSION_SLOTS; i++) begin
			if (hit_oh[i])
				hit_idx_c = hit_idx_c | SLOT_W'(i);
			if (free_oh[i])
				free_idx_c = free_idx_c | SLOT_W'(i);
		end
	end

	logic              hit_s2, full_s2, rng_s2;
	logic [SLOT_W-1:0] hit_idx_s2, free_idx_s2;
	logic [15:0]       rd_dist_s2;
	zone_t             rd_zone_s2, zone_s2;

	always_ff @(posedge clk) begin
		if (cmd.select) begin
			hit_s2      <= |match_s1;
			full_s2     <= ~|free_s1;
			hit_idx_s2  <= hit_idx_c;
			free_idx_s2 <= free_idx_c;
			rng_s2      <= ranging_q[hit_idx_c];
			rd_dist_s2  <= dist_mem[hit_idx_c];
			rd_zone_s2  <= zone_mem[hit_idx_c];
			zone_s2     <= zone_s1;
		end
	end

	// execute: result and write-back
	logic             do_create, do_destroy, do_start, do_stop, do_result;
	status_t          r_status;
	logic [KEY_W-1:0] r_sid;
	logic [15:0]      r_dist;
	zone_t            r_zone;
	logic             r_chg, r_rng;

	always_comb begin
		do_create  = 1'b0;
		do_destroy = 1'b0;
		do_start   = 1'b0;
		do_stop    = 1'b0;
		do_result  = 1'b0;
		r_status   = STAT_NOT_FOUND;
		r_sid      = '0;
		r_dist     = '0;
		r_zone     = ZN_LOCKED;
		r_chg      = 1'b0;
		r_rng      = 1'b0;
		unique case (mode_t'(mode_q))
			MODE_CREATE: begin
				if (full_s2) begin
					r_status = STAT_FULL;
				end else begin
					do_create = 1'b1;
					r_status  = STAT_OK;
					r_sid     = {chan_q, pre_q, 16'(free_idx_s2)};
					r_dist    = DIST_NONE;
				end
			end
			MODE_DESTROY, MODE_START, MODE_STOP, MODE_RESULT, MODE_QUERY: begin
				r_sid = key_q;
				if (hit_s2) begin
					r_status = STAT_OK;
					r_dist   = rd_dist_s2;
					r_zone   = rd_zone_s2;
					r_rng    = rng_s2;
					unique case (mode_t'(mode_q))
						MODE_DESTROY: do_destroy = 1'b1;
						MODE_START: begin
							do_start = 1'b1;
							r_rng    = 1'b1;
						end
						MODE_STOP: begin
							do_stop = 1'b1;
							r_rng   = 1'b0;
						end
						MODE_RESULT: begin
							do_result = 1'b1;
							r_dist    = meas_q;
							r_zone    = zone_s2;
							r_chg     = (zone_s2 != rd_zone_s2);
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			ranging_q <= '0;
		end else if (cmd.execute) begin
			if (do_create) begin
				active_q[free_idx_s2]  <= 1'b1;
				ranging_q[free_idx_s2] <= 1'b0;
			end
			if (do_destroy)
				active_q[hit_idx_s2] <= 1'b0;
			if (do_start)
				ranging_q[hit_idx_s2] <= 1'b1;
			if (do_stop)
				ranging_q[hit_idx_s2] <= 1'b0;
		end
	end

	logic [SLOT_W-1:0] wr_idx;
	assign wr_idx = do_create ? free_idx_s2 : hit_idx_s2;

	always_ff @(posedge clk) begin
		if (cmd.execute && do_create)
			ident_q[free_idx_s2] <= r_sid;
		if (cmd.execute && (do_create || do_result)) begin
			dist_mem[wr_idx] <= r_dist;
			zone_mem[wr_idx] <= r_zone;
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.execute)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			m_tuser <= r_status;
			m_tdata <= {3'b000, r_rng, r_chg, r_zone, r_dist, r_sid};
		end
	end

	assign m_tvalid      = out_valid_q;
	assign stat.out_full = out_valid_q;

endmodule

@@ rtl/core/session_distance_zone_tracker.sv @@
// top level of the session distance zone tracker: stream ports, limit registers
// depends on sdzt_pkg, sdzt_ctrl and sdzt_datapath
//
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata channel, preamble, session_key, measured_cm
//                                    tuser mode
// m_*       out  m_tvalid/m_tready   tdata session_out, distance_out, zone, zone_changed,
//                                    ranging_on; tuser status
// cfg_*     in   cfg_we              cfg_index selects limit, cfg_wdata value
//
// one beat in, one beat out; an accepted beat passes the compare, lowest-slot select
// with table read, and write-back steps of the sequencer, and write-back loads the
// result register when it is free; the next beat is taken only after write-back,
// so a new item is not taken before the last one is through
// reset: session active and ranging flags and the limits clear at once, no clearing pass;
// identifiers, distances and zones hold whatever they had until a create writes them
// stalls: a result that is not taken holds the sequencer in its write-back step
// and keeps s_tready low; a taken result frees the register in the same cycle
module session_distance_zone_tracker
	import sdzt_pkg::*;
#(
	parameter int SESSION_SLOTS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [7:0] channel, [15:8] preamble, [47:16] session_key, [63:48] measured_cm
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// [2:0] mode
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] session_out, [47:32] distance_out, [50:48] zone, [51] zone_changed,
	// [52] ranging_on, [55:53] zero
	output logic [OUT_DATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [OUT_USER_W-1:0] m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [LIMIT_W-1:0]    cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: idle, compare, select, write-back
	sdzt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, lookup and result register
	sdzt_datapath #(
		.SESSION_SLOTS (SESSION_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

@@ rtl/core/sdzt_checker.sv @@
// port-level checks of the session distance zone tracker
// depends on sdzt_pkg; bound to the top level below
module sdzt_checker
	import sdzt_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	// one item at a time: no beat right after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// full table reports an all-zero payload
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_FULL) |-> (m_tdata == '0))
		else $error("table full with nonzero payload");

	// miss or unused mode: no distance, locked zone, no flags
	a_miss_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_NOT_FOUND) |-> (m_tdata[55:32] == '0))
		else $error("not found with stored fields");

	// results never carry the unused status code
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK) || (m_tuser == STAT_NOT_FOUND) || (m_tuser == STAT_FULL))
		else $error("bad status code");

endmodule

bind session_distance_zone_tracker sdzt_checker u_sdzt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
